>>> hdl/ifp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_pkg
// Shared constants, widths and transaction types of the I/Q FIR pulse shaper.
// ----------------------------------------------------------------------------
package ifp_pkg;

  localparam int TAPS        = 33;
  localparam int SAMPLE_BITS = 16;
  localparam int COEFF_BITS  = 16;
  localparam int IDX_W       = 6;

  localparam int TAP_AW = $clog2(TAPS);
  localparam int PROD_W = SAMPLE_BITS + COEFF_BITS;
  localparam int ACC_W  = PROD_W + $clog2(TAPS);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic                          req_type;
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;
    logic [IDX_W-1:0]              coeff_index;
    logic signed [COEFF_BITS-1:0]  coeff_value;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered_i;
    logic signed [SAMPLE_BITS-1:0] filtered_q;
    logic                          clipped;
  } rsp_t;

  typedef struct packed {
    logic                          is_write;
    logic                          idx_ok;
    logic [TAP_AW-1:0]             addr;
    logic signed [COEFF_BITS-1:0]  coef;
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;
  } cmd_t;

endpackage

>>> hdl/ifp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ifp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/ifp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_front
// Input stage: accepts request transactions, classifies them and queues the
// resulting commands for the filter engine.
// ----------------------------------------------------------------------------
module ifp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ifp_pkg::req_t in_data,
  output logic          cmd_valid,
  output ifp_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  import ifp_pkg::*;

  cmd_t            q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;
  cmd_t            cmd_in;
  logic            push;

  always_comb begin
    cmd_in.is_write = (in_data.req_type == REQ_WRITE);
    cmd_in.idx_ok   = (32'(in_data.coeff_index) < 32'(TAPS));
    cmd_in.addr     = TAP_AW'(in_data.coeff_index);
    cmd_in.coef     = in_data.coeff_value;
    cmd_in.sample_i = in_data.sample_i;
    cmd_in.sample_q = in_data.sample_q;
  end

  assign in_ready  = (count != Q_CW'(Q_DEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, cmd_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> count != '0)
    else $error("command popped from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CW'(Q_DEPTH))
    else $error("command queue overfilled");

endmodule

>>> hdl/ifp_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifp_mac
// Filter engine: applies coefficient writes, stores pushed symbols in the
// circular delay line and runs one multiply-accumulate per tap on both rails.
// ----------------------------------------------------------------------------
module ifp_mac (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  ifp_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output ifp_pkg::rsp_t out_data
);

  import ifp_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]          state;
  logic [TAP_AW-1:0]   k;
  logic [TAP_AW-1:0]   pos;
  logic [TAP_AW-1:0]   wp;
  logic [TAPS-1:0]     dl_valid;
  logic [TAPS-1:0]     cw_valid;

  logic                dl_we;
  logic                cw_we;
  logic [2*SAMPLE_BITS-1:0] dl_rdata;
  logic [COEFF_BITS-1:0]    cw_rdata;

  logic                rd_vld;
  logic                rd_last;
  logic                rd_dv;
  logic                rd_cv;
  logic signed [SAMPLE_BITS-1:0] di;
  logic signed [SAMPLE_BITS-1:0] dq;
  logic signed [COEFF_BITS-1:0]  cw;

  logic                       prod_vld;
  logic                       prod_last;
  logic signed [PROD_W-1:0]   prod_i;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_i;
  logic signed [ACC_W-1:0]    acc_q;
  logic                       acc_done;

  logic [SAMPLE_BITS:0] sat_i;
  logic [SAMPLE_BITS:0] sat_q;
  logic                 out_load;

  function automatic logic [SAMPLE_BITS:0] scale_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0]         biased;
    logic signed [ACC_W-1:0]         shifted;
    logic [ACC_W-SAMPLE_BITS:0]      upper;
    logic                            fits;
    logic [SAMPLE_BITS-1:0]          value;
    biased  = acc + $signed({{(ACC_W-COEFF_BITS+1){1'b0}},
                             {(COEFF_BITS-1){acc[ACC_W-1]}}});
    shifted = biased >>> (COEFF_BITS - 1);
    upper   = shifted[ACC_W-1:SAMPLE_BITS-1];
    fits    = (&upper) || !(|upper);
    if (fits) begin
      value = shifted[SAMPLE_BITS-1:0];
    end else if (shifted[ACC_W-1]) begin
      value = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      value = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return {value, !fits};
  endfunction

  assign cmd_pop = (state == S_IDLE) && cmd_valid;
  assign dl_we   = cmd_pop && !cmd.is_write;
  assign cw_we   = cmd_pop && cmd.is_write && cmd.idx_ok;

  ifp_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (TAPS)
  ) u_dl_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (wp),
    .wdata ({cmd.sample_i, cmd.sample_q}),
    .raddr (pos),
    .rdata (dl_rdata)
  );

  ifp_ram #(
    .WIDTH (COEFF_BITS),
    .DEPTH (TAPS)
  ) u_cw_ram (
    .clk   (clk),
    .we    (cw_we),
    .waddr (cmd.addr),
    .wdata (cmd.coef),
    .raddr (k),
    .rdata (cw_rdata)
  );

  assign di = rd_dv ? $signed(dl_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0;
  assign dq = rd_dv ? $signed(dl_rdata[SAMPLE_BITS-1:0]) : '0;
  assign cw = rd_cv ? $signed(cw_rdata) : '0;

  assign sat_i    = scale_sat(acc_i);
  assign sat_q    = scale_sat(acc_q);
  assign out_load = (state == S_DRAIN) && acc_done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    rd_dv  <= dl_valid[pos];
    rd_cv  <= cw_valid[k];
    prod_i <= PROD_W'(di * cw);
    prod_q <= PROD_W'(dq * cw);
    if (out_load) begin
      out_data.filtered_i <= sat_i[SAMPLE_BITS:1];
      out_data.filtered_q <= sat_q[SAMPLE_BITS:1];
      out_data.clipped    <= sat_i[0] || sat_q[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      pos       <= '0;
      wp        <= '0;
      dl_valid  <= '0;
      cw_valid  <= '0;
      rd_vld    <= 1'b0;
      rd_last   <= 1'b0;
      prod_vld  <= 1'b0;
      prod_last <= 1'b0;
      acc_i     <= '0;
      acc_q     <= '0;
      acc_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld    <= (state == S_RUN);
      rd_last   <= (state == S_RUN) && (k == TAP_AW'(TAPS - 1));
      prod_vld  <= rd_vld;
      prod_last <= rd_last;
      if (prod_vld) begin
        acc_i <= acc_i + ACC_W'(prod_i);
        acc_q <= acc_q + ACC_W'(prod_q);
        if (prod_last) begin
          acc_done <= 1'b1;
        end
      end
      if (cw_we) begin
        cw_valid[cmd.addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (dl_we) begin
            dl_valid[wp] <= 1'b1;
            pos          <= wp;
            k            <= '0;
            wp           <= (wp == TAP_AW'(TAPS - 1)) ? '0 : wp + 1'b1;
            acc_i        <= '0;
            acc_q        <= '0;
            acc_done     <= 1'b0;
            state        <= S_RUN;
          end
        end
        S_RUN: begin
          k   <= k + 1'b1;
          pos <= (pos == '0) ? TAP_AW'(TAPS - 1) : pos - 1'b1;
          if (k == TAP_AW'(TAPS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !rd_vld && !prod_vld)
    else $error("tap pipeline busy while engine idle");

  a_last_sets_done: assert property (@(posedge clk) disable iff (rst)
    prod_vld && prod_last |=> acc_done)
    else $error("last tap did not complete accumulation");

  a_tap_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> k <= TAP_AW'(TAPS - 1) && pos <= TAP_AW'(TAPS - 1))
    else $error("tap counter out of range");

endmodule

>>> hdl/iq_fir_pulse_shaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_fir_pulse_shaper
// Complex (I/Q) FIR pulse shaper with a shared real coefficient table.
// ----------------------------------------------------------------------------
// A push transaction stores one I/Q symbol in a circular delay line of TAPS
// entries and yields one filtered I/Q result; a coefficient write transaction
// loads one tap and yields nothing (indexes of TAPS and above are dropped).
// A push occupies the filter engine until its result is loaded: the engine
// stores the symbol, then runs one multiply-accumulate per tap through the
// single read port of the delay-line and coefficient RAMs, the registered
// RAM read, the multiply register and the accumulator, and finally rounds and
// saturates the sum into the output register. A coefficient write is applied
// while the engine is idle and starts no filter run. A two-entry command queue
// sits ahead of the engine, so up to two input transactions are taken while
// the engine works or a result waits; beyond that the input stalls. Delay line,
// write pointer and coefficients read as zero after reset.
// ----------------------------------------------------------------------------
module iq_fir_pulse_shaper (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ifp_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ifp_pkg::rsp_t out_data
);

  import ifp_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  ifp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  ifp_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
